// ===== src/epp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// epp_pkg
// types, codes and calendar tables shared by the timestamp parser pipeline
// ----------------------------------------------------------------------------
package epp_pkg;

  localparam int unsigned TsLen = 14;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_SHORT   = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  localparam logic [3:0] CURSOR_FULL = 4'd14;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;

  // flags that ride along every stage
  typedef struct packed {
    logic short_len;
    logic next_present;
    logic bad;
  } flags_t;

  typedef struct packed {
    logic [13:0] year;
    logic [6:0]  mon;
    logic [6:0]  day;
    logic [6:0]  hh;
    logic [6:0]  mm;
    logic [6:0]  ss;
    logic        leap;
    flags_t      flags;
  } dec_t;

  typedef struct packed {
    logic [13:0] y;
    logic [8:0]  doy;
    logic [16:0] tod;
    flags_t      flags;
  } fld_t;

  typedef struct packed {
    logic signed [23:0] days;
    logic [16:0]        tod;
    flags_t             flags;
  } days_t;

  typedef struct packed {
    logic signed [41:0] sec;
    flags_t             flags;
  } sec_t;

  function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
    logic [4:0] dim;
    case (mon)
      4'd2:    dim = leap ? 5'd29 : 5'd28;
      4'd4:    dim = 5'd30;
      4'd6:    dim = 5'd30;
      4'd9:    dim = 5'd30;
      4'd11:   dim = 5'd30;
      default: dim = 5'd31;
    endcase
    return dim;
  endfunction

  // days before the start of a month, year starting in march
  function automatic logic [8:0] march_days(input logic [3:0] mp);
    logic [8:0] cum;
    case (mp)
      4'd0:    cum = 9'd0;
      4'd1:    cum = 9'd31;
      4'd2:    cum = 9'd61;
      4'd3:    cum = 9'd92;
      4'd4:    cum = 9'd122;
      4'd5:    cum = 9'd153;
      4'd6:    cum = 9'd184;
      4'd7:    cum = 9'd214;
      4'd8:    cum = 9'd245;
      4'd9:    cum = 9'd275;
      4'd10:   cum = 9'd306;
      4'd11:   cum = 9'd337;
      default: cum = 9'd0;
    endcase
    return cum;
  endfunction

endpackage
`default_nettype wire

// ===== src/epp_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// epp_decode
// character check and digit to field conversion, first pipeline stage
// ----------------------------------------------------------------------------
module epp_decode
  import epp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        vld_i,
  input  wire logic [63:0] date_chars_i,
  input  wire logic [47:0] time_chars_i,
  input  wire logic        have_fourteen_i,
  input  wire logic        next_present_i,
  input  wire logic [7:0]  next_char_i,
  output logic             vld_o,
  output dec_t             data_o
);

  logic [7:0]  ch   [TsLen];
  logic [3:0]  dg   [TsLen];
  logic [7:0]  nv;
  logic [4:0]  cent_mod;
  logic        non_digit;
  logic        c100;
  logic        c400;
  logic        vld_q;
  dec_t        data_d, data_q;

  always_comb begin
    non_digit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      ch[i] = date_chars_i[63 - 8 * i -: 8];
    end
    for (int i = 0; i < 6; i++) begin
      ch[8 + i] = time_chars_i[47 - 8 * i -: 8];
    end
    for (int i = 0; i < TsLen; i++) begin
      dg[i] = 4'(ch[i] - ASCII_ZERO);
      if ((ch[i] - ASCII_ZERO) > 8'd9) begin
        non_digit = 1'b1;
      end
    end
    nv = next_char_i - ASCII_ZERO;

    c100     = (dg[2] == 4'd0) && (dg[3] == 4'd0);
    cent_mod = {dg[0], 1'b0} + 5'(dg[1]);
    c400     = c100 && (cent_mod[1:0] == 2'd0);

    data_d.year = 14'(dg[0]) * 14'd1000 + 14'(dg[1]) * 14'd100
                + 14'(dg[2]) * 14'd10 + 14'(dg[3]);
    data_d.mon  = 7'(dg[4]) * 7'd10 + 7'(dg[5]);
    data_d.day  = 7'(dg[6]) * 7'd10 + 7'(dg[7]);
    data_d.hh   = 7'(dg[8]) * 7'd10 + 7'(dg[9]);
    data_d.mm   = 7'(dg[10]) * 7'd10 + 7'(dg[11]);
    data_d.ss   = 7'(dg[12]) * 7'd10 + 7'(dg[13]);
    data_d.leap = (data_d.year[1:0] == 2'd0) && (!c100 || c400);
    data_d.flags.short_len    = !have_fourteen_i;
    data_d.flags.next_present = next_present_i;
    data_d.flags.bad          = non_digit || (next_present_i && (nv <= 8'd9));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule
`default_nettype wire

// ===== src/epp_field.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// epp_field
// field range and month length checks, march-based year and day of year
// ----------------------------------------------------------------------------
module epp_field
  import epp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic vld_i,
  input  wire dec_t data_i,
  output logic      vld_o,
  output fld_t      data_o
);

  logic       range_bad;
  logic [4:0] dim;
  logic [3:0] mp;
  logic       early;
  logic       vld_q;
  fld_t       data_d, data_q;

  always_comb begin
    dim   = month_days(data_i.mon[3:0], data_i.leap);
    early = (data_i.mon <= 7'd2);
    range_bad = (data_i.hh >= 7'd24) || (data_i.mm >= 7'd60) || (data_i.ss >= 7'd60)
             || (data_i.mon < 7'd1) || (data_i.mon > 7'd12) || (data_i.day == 7'd0);
    if (!range_bad && (data_i.day > 7'(dim))) begin
      range_bad = 1'b1;
    end
    mp = early ? 4'(data_i.mon + 7'd9) : 4'(data_i.mon - 7'd3);

    data_d.y   = data_i.year + 14'd400 - 14'(early);
    data_d.doy = march_days(mp) + 9'(data_i.day) - 9'd1;
    data_d.tod = 17'(data_i.hh) * 17'd3600 + 17'(data_i.mm) * 17'd60 + 17'(data_i.ss);
    data_d.flags     = data_i.flags;
    data_d.flags.bad = data_i.flags.bad || range_bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule
`default_nettype wire

// ===== src/epp_days.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// epp_days
// day count since 1970-01-01 from march-based year and day of year
// ----------------------------------------------------------------------------
module epp_days
  import epp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic vld_i,
  input  wire fld_t data_i,
  output logic      vld_o,
  output days_t     data_o
);

  localparam logic [26:0] Recip100 = 27'd5243;
  localparam logic signed [23:0] DayBias = 24'sd865565;

  logic [26:0] prod;
  logic [13:0] q100;
  logic signed [23:0] sum;
  logic        vld_q;
  days_t       data_d, data_q;

  always_comb begin
    // y / 100 by reciprocal, exact for y below 43690
    prod = 27'(data_i.y) * Recip100;
    q100 = 14'(prod >> 19);
    sum  = $signed(24'(data_i.y) * 24'd365) + $signed(24'(data_i.y >> 2))
         - $signed(24'(q100)) + $signed(24'(q100 >> 2)) + $signed(24'(data_i.doy));
    data_d.days  = sum - DayBias;
    data_d.tod   = data_i.tod;
    data_d.flags = data_i.flags;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule
`default_nettype wire

// ===== src/epp_seconds.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// epp_seconds
// signed seconds since the epoch from day count and second of day
// ----------------------------------------------------------------------------
module epp_seconds
  import epp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire logic  vld_i,
  input  wire days_t data_i,
  output logic       vld_o,
  output sec_t       data_o
);

  localparam logic signed [41:0] SecPerDay = 42'sd86400;

  logic  vld_q;
  sec_t  data_d, data_q;

  always_comb begin
    data_d.sec   = 42'(data_i.days) * SecPerDay + $signed(42'(data_i.tod));
    data_d.flags = data_i.flags;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign vld_o  = vld_q;
  assign data_o = data_q;

endmodule
`default_nettype wire

// ===== src/timestamp_to_epoch_parser.sv =====
// throughput: one beat per cycle unless the output stalls, five stages share one enable
// a stalled output holds every stage in place, input ready follows the output side
// reset: asynchronous active low, clears all stage valid bits, payload is not reset
`default_nettype none
// ----------------------------------------------------------------------------
// timestamp_to_epoch_parser
// parses a YYYYMMDDHHMMSS ascii timestamp into unsigned unix epoch seconds
// ----------------------------------------------------------------------------
module timestamp_to_epoch_parser
  import epp_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // date_chars [63:0], time_chars [111:64], next_char [119:112]
  input  wire logic [119:0] s_axis_tdata,
  // have_fourteen [0], next_present [1]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // epoch_seconds [31:0], cursor_offset [35:32], zero [39:36]
  output logic [39:0]       m_axis_tdata,
  // status [1:0]
  output logic [1:0]        m_axis_tuser
);

  logic  en;
  logic  dec_vld, fld_vld, days_vld, sec_vld;
  dec_t  dec_data;
  fld_t  fld_data;
  days_t days_data;
  sec_t  sec_data;

  logic        out_vld_q;
  logic [31:0] epoch_q, epoch_d;
  logic [1:0]  status_q, status_d;
  logic [3:0]  cursor_q, cursor_d;
  logic        out_of_range;

  assign en = !out_vld_q || m_axis_tready;

  epp_decode u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (en),
    .vld_i           (s_axis_tvalid),
    .date_chars_i    (s_axis_tdata[63:0]),
    .time_chars_i    (s_axis_tdata[111:64]),
    .have_fourteen_i (s_axis_tuser[0]),
    .next_present_i  (s_axis_tuser[1]),
    .next_char_i     (s_axis_tdata[119:112]),
    .vld_o           (dec_vld),
    .data_o          (dec_data)
  );

  epp_field u_field (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (dec_vld),
    .data_i (dec_data),
    .vld_o  (fld_vld),
    .data_o (fld_data)
  );

  epp_days u_days (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (fld_vld),
    .data_i (fld_data),
    .vld_o  (days_vld),
    .data_o (days_data)
  );

  epp_seconds u_seconds (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (days_vld),
    .data_i (days_data),
    .vld_o  (sec_vld),
    .data_o (sec_data)
  );

  always_comb begin
    out_of_range = sec_data.sec[41] || (sec_data.sec[40:32] != 9'd0);
    if (sec_data.flags.short_len) begin
      epoch_d  = 32'd0;
      status_d = STATUS_SHORT;
      cursor_d = 4'd0;
    end else if (sec_data.flags.bad || out_of_range) begin
      epoch_d  = 32'd0;
      status_d = STATUS_INVALID;
      cursor_d = sec_data.flags.next_present ? CURSOR_FULL : 4'd0;
    end else begin
      epoch_d  = sec_data.sec[31:0];
      status_d = STATUS_OK;
      cursor_d = CURSOR_FULL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= sec_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      epoch_q  <= epoch_d;
      status_q <= status_d;
      cursor_q <= cursor_d;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'd0, cursor_q, epoch_q};
  assign m_axis_tuser  = status_q;

`ifndef SYNTHESIS
  a_ok_cursor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == STATUS_OK)) |-> (m_axis_tdata[35:32] == CURSOR_FULL))
    else $error("ok beat without full cursor");

  a_short_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == STATUS_SHORT)) |-> (m_axis_tdata == 40'd0))
    else $error("short beat with nonzero epoch or cursor");

  a_err_epoch_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == STATUS_INVALID)) |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("invalid beat with nonzero epoch");

  a_stall_backpressure : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input ready while output stalled");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/timestamp_to_epoch_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timestamp_to_epoch_parser_tb
// drives YYYYMMDDHHMMSS stamps through the stream ports with bursty input and
// a stalling output, predicts status, cursor and epoch seconds per beat, and
// compares every output beat in order against the prediction
// ----------------------------------------------------------------------------
module timestamp_to_epoch_parser_tb;
  import epp_pkg::*;

  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandomBeats = 400;
  localparam int unsigned HoldCycles  = 80;
  localparam longint      EpochMax    = 64'd4294967295;

  typedef struct packed {
    logic [63:0] date_chars;
    logic [47:0] time_chars;
    logic        have_fourteen;
    logic        next_present;
    logic [7:0]  next_char;
  } ts_beat_t;

  typedef struct packed {
    logic [31:0] epoch;
    logic [1:0]  status;
    logic [3:0]  cursor;
  } epoch_result_t;

  class epoch_checker;
    epoch_result_t pending_epochs[$];
    int unsigned   mismatches;
    int unsigned   seen_beats;
    int unsigned   month_len [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    function new();
      mismatches = 0;
      seen_beats = 0;
    endfunction

    function longint days_from_civil(int unsigned year, int unsigned m, int unsigned d);
      int unsigned y;
      int unsigned era;
      int unsigned yoe;
      int unsigned mp;
      int unsigned doy;
      int unsigned doe;
      y   = year + 400 - ((m <= 2) ? 1 : 0);
      era = y / 400;
      yoe = y - era * 400;
      mp  = (m > 2) ? (m - 3) : (m + 9);
      doy = (153 * mp + 2) / 5 + d - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return (longint'(era) - 1) * 146097 + longint'(doe) - 719468;
    endfunction

    function epoch_result_t parse_stamp(ts_beat_t b);
      epoch_result_t r;
      logic [7:0]    ch [14];
      logic [7:0]    v;
      int unsigned   dg [14];
      int unsigned   year, mon, day, hh, mm, ss, dim;
      bit            bad;
      bit            leap;
      longint        sec;
      r.epoch  = '0;
      r.status = STATUS_SHORT;
      r.cursor = '0;
      if (!b.have_fourteen) return r;
      bad = 1'b0;
      for (int i = 0; i < 8; i++) ch[i] = b.date_chars[63 - 8 * i -: 8];
      for (int i = 0; i < 6; i++) ch[8 + i] = b.time_chars[47 - 8 * i -: 8];
      for (int i = 0; i < 14; i++) begin
        v = ch[i] - ASCII_ZERO;
        if (v > 8'd9) bad = 1'b1;
        dg[i] = 32'(v);
      end
      if (!bad) begin
        year = dg[0] * 1000 + dg[1] * 100 + dg[2] * 10 + dg[3];
        mon  = dg[4] * 10 + dg[5];
        day  = dg[6] * 10 + dg[7];
        hh   = dg[8] * 10 + dg[9];
        mm   = dg[10] * 10 + dg[11];
        ss   = dg[12] * 10 + dg[13];
        if (hh >= 24 || mm >= 60 || ss >= 60) bad = 1'b1;
        if (mon < 1 || mon > 12 || day == 0) bad = 1'b1;
        if (!bad) begin
          leap = (year % 4 == 0) && ((year % 100 != 0) || (year % 400 == 0));
          dim  = month_len[mon - 1];
          if (mon == 2 && leap) dim = dim + 1;
          if (day > dim) bad = 1'b1;
        end
        if (!bad) begin
          sec = days_from_civil(year, mon, day) * 86400 + longint'(hh * 3600 + mm * 60 + ss);
          if (sec < 0 || sec > EpochMax) bad = 1'b1;
          else r.epoch = sec[31:0];
        end
      end
      if (b.next_present) begin
        v = b.next_char - ASCII_ZERO;
        if (v <= 8'd9) bad = 1'b1;
      end
      if (bad) begin
        r.status = STATUS_INVALID;
        r.cursor = b.next_present ? CURSOR_FULL : 4'd0;
        r.epoch  = '0;
      end else begin
        r.status = STATUS_OK;
        r.cursor = CURSOR_FULL;
      end
      return r;
    endfunction

    function void note_stamp(ts_beat_t b);
      pending_epochs.push_back(parse_stamp(b));
    endfunction

    function int unsigned pending();
      return pending_epochs.size();
    endfunction

    task report_mismatch(string what, longint got, longint want);
      mismatches++;
      $display("mismatch at output beat %0d: %s got %0d expected %0d",
               seen_beats, what, got, want);
    endtask

    task check_epoch(logic [39:0] data, logic [1:0] user);
      epoch_result_t want;
      if (pending_epochs.size() == 0) begin
        report_mismatch("beat with nothing pending, epoch", data[31:0], 0);
      end else begin
        want = pending_epochs.pop_front();
        if (data[31:0] !== want.epoch) report_mismatch("epoch_seconds", data[31:0], want.epoch);
        if (user !== want.status) report_mismatch("status", user, want.status);
        if (data[35:32] !== want.cursor) report_mismatch("cursor_offset", data[35:32], want.cursor);
        if (data[39:36] !== 4'd0) report_mismatch("padding", data[39:36], 0);
      end
      seen_beats++;
    endtask
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  epoch_checker sb;
  ts_beat_t     seen;
  int unsigned  burst_left = 0;
  bit           hold_req = 1'b0;
  bit           hold_done = 1'b0;
  bit           hold_active = 1'b0;
  int unsigned  cycles = 0;

  timestamp_to_epoch_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic ts_beat_t make_stamp(int unsigned year, int unsigned mon, int unsigned day,
                                          int unsigned hh, int unsigned mm, int unsigned ss,
                                          bit next_present, logic [7:0] next_char);
    ts_beat_t b;
    int unsigned two [5];
    b.date_chars[63:56] = 8'(year / 1000 % 10) + ASCII_ZERO;
    b.date_chars[55:48] = 8'(year / 100 % 10) + ASCII_ZERO;
    b.date_chars[47:40] = 8'(year / 10 % 10) + ASCII_ZERO;
    b.date_chars[39:32] = 8'(year % 10) + ASCII_ZERO;
    two = '{mon, day, hh, mm, ss};
    for (int i = 0; i < 2; i++) begin
      b.date_chars[31 - 16 * i -: 8] = 8'(two[i] / 10 % 10) + ASCII_ZERO;
      b.date_chars[23 - 16 * i -: 8] = 8'(two[i] % 10) + ASCII_ZERO;
    end
    for (int i = 0; i < 3; i++) begin
      b.time_chars[47 - 16 * i -: 8] = 8'(two[2 + i] / 10 % 10) + ASCII_ZERO;
      b.time_chars[39 - 16 * i -: 8] = 8'(two[2 + i] % 10) + ASCII_ZERO;
    end
    b.have_fourteen = 1'b1;
    b.next_present  = next_present;
    b.next_char     = next_char;
    return b;
  endfunction

  function automatic ts_beat_t set_char(ts_beat_t b, int unsigned pos, logic [7:0] c);
    if (pos < 8) b.date_chars[63 - 8 * pos -: 8] = c;
    else b.time_chars[47 - 8 * (pos - 8) -: 8] = c;
    return b;
  endfunction

  function automatic ts_beat_t random_stamp();
    ts_beat_t    b;
    int unsigned year, mon, day, hh, mm, ss;
    logic [7:0]  nc;
    if ($urandom_range(0, 99) < 10) begin
      b.date_chars    = {$urandom, $urandom};
      b.time_chars    = {16'($urandom), $urandom};
      b.have_fourteen = 1'($urandom);
      b.next_present  = 1'($urandom);
      b.next_char     = 8'($urandom);
      return b;
    end
    year = ($urandom_range(0, 9) < 7) ? $urandom_range(1965, 2110) : $urandom_range(0, 9999);
    mon  = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 12) : $urandom_range(0, 99);
    day  = ($urandom_range(0, 19) < 17) ? $urandom_range(1, 28) : $urandom_range(0, 32);
    hh   = ($urandom_range(0, 19) < 18) ? $urandom_range(0, 23) : $urandom_range(24, 99);
    mm   = ($urandom_range(0, 19) < 18) ? $urandom_range(0, 59) : $urandom_range(60, 99);
    ss   = ($urandom_range(0, 19) < 18) ? $urandom_range(0, 59) : $urandom_range(60, 99);
    nc   = ($urandom_range(0, 9) < 3) ? 8'($urandom_range(0, 9)) + ASCII_ZERO : 8'($urandom);
    b = make_stamp(year, mon, day, hh, mm, ss, 1'($urandom), nc);
    if ($urandom_range(0, 99) < 8) b = set_char(b, $urandom_range(0, 13), 8'($urandom));
    if ($urandom_range(0, 99) < 5) b.have_fourteen = 1'b0;
    return b;
  endfunction

  task automatic send_beat(input ts_beat_t b);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b.next_char, b.time_chars, b.date_chars};
    s_axis_tuser  <= {b.next_present, b.have_fourteen};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic offer(input ts_beat_t b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (!hold_active && gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    send_beat(b);
  endtask

  task automatic run_directed();
    // epoch zero, last second that fits, one past it
    offer(make_stamp(1970, 1, 1, 0, 0, 0, 1'b0, 8'h00));
    offer(make_stamp(2106, 2, 7, 6, 28, 15, 1'b0, 8'h00));
    offer(make_stamp(2106, 2, 7, 6, 28, 16, 1'b0, 8'h00));
    // before 1970, year zero leap day, far too late
    offer(make_stamp(1969, 12, 31, 23, 59, 59, 1'b1, "Z"));
    offer(make_stamp(0, 2, 29, 0, 0, 0, 1'b0, 8'h00));
    offer(make_stamp(9999, 12, 31, 23, 59, 59, 1'b1, 8'hFF));
    // short buffer wins over everything else, then stamps of all zero bytes and all one bits
    offer('{date_chars: "20000101",
            time_chars: 48'h303030303030, have_fourteen: 1'b0,
            next_present: 1'b1, next_char: "7"});
    offer('{date_chars: '0, time_chars: '0, have_fourteen: 1'b1,
            next_present: 1'b0, next_char: '0});
    offer('{date_chars: '1, time_chars: '1, have_fourteen: 1'b1,
            next_present: 1'b1, next_char: '1});
    // trailing character handling
    offer(make_stamp(2000, 2, 29, 12, 34, 56, 1'b1, "9"));
    offer(make_stamp(2000, 2, 29, 12, 34, 56, 1'b1, "0"));
    offer(make_stamp(2000, 2, 29, 12, 34, 56, 1'b1, 8'h2F));
    offer(make_stamp(2000, 2, 29, 12, 34, 56, 1'b1, 8'h3A));
    offer(make_stamp(2000, 2, 29, 12, 34, 56, 1'b0, "5"));
    // leap rules
    offer(make_stamp(2100, 2, 29, 0, 0, 0, 1'b0, 8'h00));
    offer(make_stamp(2100, 2, 28, 23, 59, 59, 1'b0, 8'h00));
    offer(make_stamp(2024, 2, 29, 1, 2, 3, 1'b0, 8'h00));
    offer(make_stamp(2023, 2, 29, 1, 2, 3, 1'b1, " "));
    // field ranges
    offer(make_stamp(2000, 1, 1, 24, 0, 0, 1'b0, 8'h00));
    offer(make_stamp(2000, 1, 1, 0, 60, 0, 1'b0, 8'h00));
    offer(make_stamp(2000, 1, 1, 0, 0, 60, 1'b0, 8'h00));
    offer(make_stamp(2000, 0, 10, 0, 0, 0, 1'b0, 8'h00));
    offer(make_stamp(2000, 13, 10, 0, 0, 0, 1'b0, 8'h00));
    offer(make_stamp(2000, 5, 0, 0, 0, 0, 1'b0, 8'h00));
    offer(make_stamp(2000, 5, 32, 0, 0, 0, 1'b0, 8'h00));
    offer(make_stamp(2001, 4, 31, 0, 0, 0, 1'b0, 8'h00));
    // characters just outside the digit range inside the stamp
    offer(set_char(make_stamp(2010, 6, 15, 8, 30, 0, 1'b0, 8'h00), 5, 8'h3A));
    offer(set_char(make_stamp(2010, 6, 15, 8, 30, 0, 1'b0, 8'h00), 13, 8'h2F));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        seen.date_chars    = s_axis_tdata[63:0];
        seen.time_chars    = s_axis_tdata[111:64];
        seen.next_char     = s_axis_tdata[119:112];
        seen.have_fourteen = s_axis_tuser[0];
        seen.next_present  = s_axis_tuser[1];
        sb.note_stamp(seen);
      end
      if (m_axis_tvalid && m_axis_tready) sb.check_epoch(m_axis_tdata, m_axis_tuser);
    end
  end

  // output side stall pattern, with one long hold-off on request
  initial begin
    int unsigned mode;
    int unsigned len;
    forever begin
      if (hold_req && !hold_done) begin
        hold_done     = 1'b1;
        hold_active   = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_active = 1'b0;
      end else begin
        mode = $urandom_range(0, 3);
        len  = (mode == 2) ? $urandom_range(1, 6) : $urandom_range(1, 40);
        repeat (len) begin
          case (mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom);
            2: m_axis_tready <= 1'b0;
            default: m_axis_tready <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timestamp_to_epoch_parser_tb NOT OK");
    $finish;
  end

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (int unsigned n = 0; n < RandomBeats; n++) begin
      if (n == 150) hold_req = 1'b1;
      offer(random_stamp());
    end
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("timestamp_to_epoch_parser_tb OK");
    end else begin
      $display("timestamp_to_epoch_parser_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/epp_pkg.sv
src/epp_decode.sv
src/epp_field.sv
src/epp_days.sv
src/epp_seconds.sv
src/timestamp_to_epoch_parser.sv
tb/sv/timestamp_to_epoch_parser_tb.sv
